// ===== rtl/fixed_head_disk_controller_unit_macros.svh =====
// assertion macros shared by the disk controller rtl
`ifndef FIXED_HEAD_DISK_CONTROLLER_UNIT_MACROS_SVH
`define FIXED_HEAD_DISK_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define FHDC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define FHDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fhdc_pkg.sv =====
// types, constants and helpers for the fixed head disk controller
`timescale 1ns / 1ps
package fhdc_pkg;

  // disk geometry
  localparam int MAX_SURFACES       = 2;
  localparam int WORDS_PER_TRACK    = 1536;
  localparam int TRACKS_PER_SURFACE = 64;
  localparam int STORE_WORDS        = MAX_SURFACES * TRACKS_PER_SURFACE * WORDS_PER_TRACK;
  localparam int STORE_AW           = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int TRACK_COUNT        = MAX_SURFACES * TRACKS_PER_SURFACE;
  localparam int TRK_W              = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
  localparam int CHARS_PER_TRACK    = 2 * WORDS_PER_TRACK;

  // register widths
  localparam int CA_W      = 12;
  localparam int SURF_W    = 5;
  localparam int CFG_IDX_W = 1;

  // command word one layout
  localparam int CMD_WRITE_BIT = 15;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SURFACES = 1'b1;

  // bus access kinds
  localparam logic [2:0] MODE_CTRL  = 3'd0;
  localparam logic [2:0] MODE_OUT   = 3'd1;
  localparam logic [2:0] MODE_IN    = 3'd2;
  localparam logic [2:0] MODE_SENSE = 3'd3;
  localparam logic [2:0] MODE_END   = 3'd4;
  localparam logic [2:0] MODE_TICK  = 3'd5;

  // control and data function codes
  localparam logic [3:0] FN_NONE      = 4'd0;
  localparam logic [3:0] FN_START     = 4'd3;
  localparam logic [3:0] FN_STOP      = 4'd4;
  localparam logic [3:0] FN_START_ALT = 4'd7;

  // sense function codes
  localparam logic [3:0] SNS_READY    = 4'd0;
  localparam logic [3:0] SNS_NOT_BUSY = 4'd1;
  localparam logic [3:0] SNS_NO_DERR  = 4'd2;
  localparam logic [3:0] SNS_NO_AERR  = 4'd3;
  localparam logic [3:0] SNS_NO_IRQ   = 4'd4;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CW1  = 2'd1,
    PH_CW2  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    SQ_CLEAR  = 2'd0,
    SQ_RUN    = 2'd1,
    SQ_READ   = 2'd2,
    SQ_WRITE2 = 2'd3
  } seq_t;

  typedef struct packed {
    logic        skip;
    logic        bad;
    logic [15:0] rdata;
    logic        rdy;
    logic        busy;
    logic        derr;
    logic        aerr;
    logic        endq;
    logic        irq;
  } res_t;

  // read tick waiting on the disk store
  typedef struct packed {
    logic two;   // second byte read too
    logic load;  // word goes to the data buffer
    logic chk;   // end of transfer parity check
    logic odd;   // first byte sits in the low lane
  } pend_t;

  // third byte of an ending write
  typedef struct packed {
    logic                lo_lane;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          data;
  } wr2_t;

  function automatic logic byte_par(input logic [7:0] b);
    return ^b;
  endfunction

  // checksum byte is 0200 for odd parity
  function automatic logic [7:0] chk_byte(input logic par);
    return {par, 7'b0};
  endfunction

endpackage

// ===== rtl/fixed_head_disk_controller_unit.sv =====
// fixed head disk controller: bus access decode, transfer control and disk store
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  cfg     | in        | cfg_we               | cfg_index, cfg_wdata
//  in      | in        | in_valid / in_ready  | in_mode, in_function_code, in_bus_data
//  out     | out       | out_valid / out_ready| skip, bad function, read data, 6 flags
//
//  one item per cycle for control, data, sense, end and write ticks, while in_ready is high
//  read ticks hold off the next item: the disk store read returns in the cycle after issue
//  an ending write that lays data plus checksum bytes passes through a second write state (one lane writes twice)
//  after reset a sweep over all 196608 words zeroes the disk store; in_ready stays low, cfg is taken
//  a two-entry result buffer lets the input run on while a result waits on out_ready
`timescale 1ns / 1ps
`include "fixed_head_disk_controller_unit_macros.svh"

module fixed_head_disk_controller_unit
  import fhdc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SURF_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_mode,
  input  logic [3:0]           in_function_code,
  input  logic [15:0]          in_bus_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_skip,
  output logic                 out_bad_function,
  output logic [15:0]          out_read_data,
  output logic                 out_ready_flag,
  output logic                 out_busy_flag,
  output logic                 out_data_error_flag,
  output logic                 out_access_error_flag,
  output logic                 out_end_flag,
  output logic                 out_interrupt_request
);

  seq_t                seq_r, seq_nxt;
  logic [STORE_AW-1:0] clr_addr_r, clr_addr_nxt;

  logic              medium_r;
  logic [SURF_W-1:0] nsurf_r;

  logic [15:0]   cmd1_r, cmd1_nxt;
  logic [CA_W-1:0] ca_r, ca_nxt;
  logic [15:0]   buf_r, buf_nxt;
  phase_t        phase_r, phase_nxt;
  logic busy_r, busy_nxt, rdy_r, rdy_nxt, derr_r, derr_nxt, aerr_r, aerr_nxt;
  logic endq_r, endq_nxt, par_r, par_nxt, irq_r, irq_nxt, armed_r, armed_nxt;

  pend_t       pend_r, pend_nxt;
  logic [15:0] hold_dat_r, hold_dat_nxt;
  wr2_t        wr2_r, wr2_nxt;

  // disk store, one memory per byte lane
  logic [7:0]          hi_mem [STORE_WORDS];
  logic [7:0]          lo_mem [STORE_WORDS];
  logic                hi_we, hi_re, lo_we, lo_re;
  logic [STORE_AW-1:0] hi_addr, lo_addr;
  logic [7:0]          hi_wdata, lo_wdata;
  logic [7:0]          hi_q_r, lo_q_r;

  // result buffer
  res_t out_r, out_nxt, skid_r, skid_nxt, push_res;
  logic out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic push, pop, accept;
  logic res_skip, res_bad;
  logic [15:0] res_rd;

  // tick planning
  logic [3:0]          sf;
  logic [5:0]          tk;
  logic                loc_ok;
  logic [TRK_W-1:0]    trk_idx;
  logic [STORE_AW-1:0] a_cur, a_next, a_hi;
  logic [CA_W:0]       ca_ext;
  logic [2:0]          tk_ok, tk_succ;
  logic [1:0]          tk_nreq, tk_cnt;
  logic                tk_end, tk_write, tk_fault, tk_wpar;
  logic [7:0]          wb0, wb1, wb2;
  logic                w2_bad;

  // read return
  logic [7:0] rd_c1, rd_c2;
  logic       rd_par;

  assign in_ready = (seq_r == SQ_RUN) && !skid_valid_r;
  assign accept   = in_valid && in_ready;
  assign pop      = out_valid_r && out_ready;

  assign sf      = cmd1_r[13:10];
  assign tk      = cmd1_r[9:4];
  assign loc_ok  = SURF_W'(sf) < SURF_W'(MAX_SURFACES);
  assign trk_idx = TRK_W'(int'(sf) * TRACKS_PER_SURFACE + int'(tk));
  assign a_cur   = STORE_AW'(int'(trk_idx) * WORDS_PER_TRACK + int'(ca_r[CA_W-1:1]));
  assign a_next  = a_cur + STORE_AW'(1);
  // an odd address puts the first byte in the low lane, the second in the next word
  assign a_hi    = ca_r[0] ? a_next : a_cur;
  assign ca_ext  = {1'b0, ca_r};

  // word two rejects: address off the track, no medium, surface or track out of range
  assign w2_bad = ({1'b0, in_bus_data[CA_W-1:0]} >= (CA_W+1)'(CHARS_PER_TRACK)) ||
                  !medium_r ||
                  (SURF_W'(sf) >= nsurf_r) || (SURF_W'(sf) >= SURF_W'(MAX_SURFACES)) ||
                  (7'(tk) >= 7'(TRACKS_PER_SURFACE));

  always_comb begin
    tk_end   = endq_r || rdy_r;
    tk_write = cmd1_r[CMD_WRITE_BIT];
    if (!tk_end) begin
      tk_nreq = 2'd2;
    end else if (tk_write && !rdy_r) begin
      tk_nreq = 2'd3;
    end else begin
      tk_nreq = 2'd1;
    end
    tk_ok[0] = loc_ok && (ca_ext < (CA_W+1)'(CHARS_PER_TRACK));
    tk_ok[1] = loc_ok && ((ca_ext + (CA_W+1)'(1)) < (CA_W+1)'(CHARS_PER_TRACK));
    tk_ok[2] = loc_ok && ((ca_ext + (CA_W+1)'(2)) < (CA_W+1)'(CHARS_PER_TRACK));
    tk_succ[0] = tk_ok[0];
    tk_succ[1] = tk_succ[0] && tk_ok[1] && (tk_nreq >= 2'd2);
    tk_succ[2] = tk_succ[1] && tk_ok[2] && (tk_nreq == 2'd3);
    tk_fault = !tk_succ[0] || ((tk_nreq >= 2'd2) && !tk_succ[1]) ||
               ((tk_nreq == 2'd3) && !tk_succ[2]);
    if (tk_succ[2]) begin
      tk_cnt = 2'd3;
    end else if (tk_succ[1]) begin
      tk_cnt = 2'd2;
    end else if (tk_succ[0]) begin
      tk_cnt = 2'd1;
    end else begin
      tk_cnt = 2'd0;
    end
    // a write ending with ready still set lays only the checksum
    wb0 = (tk_end && rdy_r) ? chk_byte(par_r) : buf_r[15:8];
    wb1 = buf_r[7:0];
    wb2 = chk_byte(par_r ^ byte_par(wb0) ^ byte_par(wb1));
    tk_wpar = par_r ^ (tk_succ[0] & byte_par(wb0)) ^ (tk_succ[1] & byte_par(wb1)) ^
              (tk_succ[2] & byte_par(wb2));
  end

  assign rd_c1  = pend_r.odd ? lo_q_r : hi_q_r;
  assign rd_c2  = pend_r.odd ? hi_q_r : lo_q_r;
  assign rd_par = par_r ^ byte_par(rd_c1) ^ (pend_r.two & byte_par(rd_c2));

  always_comb begin
    seq_nxt      = seq_r;
    clr_addr_nxt = clr_addr_r;
    cmd1_nxt     = cmd1_r;
    ca_nxt       = ca_r;
    buf_nxt      = buf_r;
    phase_nxt    = phase_r;
    busy_nxt     = busy_r;
    rdy_nxt      = rdy_r;
    derr_nxt     = derr_r;
    aerr_nxt     = aerr_r;
    endq_nxt     = endq_r;
    par_nxt      = par_r;
    irq_nxt      = irq_r;
    armed_nxt    = armed_r;
    pend_nxt     = pend_r;
    hold_dat_nxt = hold_dat_r;
    wr2_nxt      = wr2_r;
    hi_we        = 1'b0;
    hi_re        = 1'b0;
    lo_we        = 1'b0;
    lo_re        = 1'b0;
    hi_addr      = a_hi;
    lo_addr      = a_cur;
    hi_wdata     = ca_r[0] ? wb1 : wb0;
    lo_wdata     = ca_r[0] ? wb0 : wb1;
    push         = 1'b0;
    res_skip     = 1'b0;
    res_bad      = 1'b0;
    res_rd       = in_bus_data;

    case (seq_r)
      SQ_CLEAR: begin
        hi_we    = 1'b1;
        lo_we    = 1'b1;
        hi_addr  = clr_addr_r;
        lo_addr  = clr_addr_r;
        hi_wdata = '0;
        lo_wdata = '0;
        clr_addr_nxt = clr_addr_r + STORE_AW'(1);
        if (clr_addr_r == STORE_AW'(STORE_WORDS - 1)) begin
          seq_nxt = SQ_RUN;
        end
      end

      SQ_RUN: begin
        if (accept) begin
          push = 1'b1;
          case (in_mode)
            MODE_CTRL: begin
              if (in_function_code == FN_STOP) begin
                endq_nxt = 1'b1;
                irq_nxt  = 1'b0;
              end else if (in_function_code inside {FN_START, FN_START_ALT}) begin
                if (!busy_r) begin
                  busy_nxt  = 1'b1;
                  endq_nxt  = 1'b0;
                  par_nxt   = 1'b0;
                  derr_nxt  = 1'b0;
                  aerr_nxt  = 1'b0;
                  phase_nxt = PH_CW1;
                  rdy_nxt   = 1'b1;
                end
              end else begin
                res_bad = 1'b1;
              end
            end

            MODE_OUT: begin
              if (in_function_code != FN_NONE) begin
                res_bad = 1'b1;
              end else if (rdy_r) begin
                buf_nxt  = in_bus_data;
                res_skip = 1'b1;
                case (phase_r)
                  PH_CW1: begin
                    cmd1_nxt  = in_bus_data;
                    phase_nxt = PH_CW2;
                  end
                  PH_CW2: begin
                    ca_nxt    = in_bus_data[CA_W-1:0];
                    phase_nxt = PH_IDLE;
                    if (w2_bad) begin
                      aerr_nxt = 1'b1;
                      busy_nxt = 1'b0;
                      irq_nxt  = 1'b1;
                    end else begin
                      rdy_nxt   = cmd1_r[CMD_WRITE_BIT];
                      armed_nxt = 1'b1;
                    end
                  end
                  default: begin
                    rdy_nxt = 1'b0;
                  end
                endcase
              end
            end

            MODE_IN: begin
              if (in_function_code != FN_NONE) begin
                res_bad = 1'b1;
              end else if (rdy_r) begin
                rdy_nxt  = 1'b0;
                res_rd   = in_bus_data | buf_r;
                res_skip = 1'b1;
              end
            end

            MODE_SENSE: begin
              case (in_function_code)
                SNS_READY:    res_skip = rdy_r;
                SNS_NOT_BUSY: res_skip = !busy_r;
                SNS_NO_DERR:  res_skip = !derr_r;
                SNS_NO_AERR:  res_skip = !aerr_r;
                SNS_NO_IRQ:   res_skip = !irq_r;
                default:      res_skip = 1'b0;
              endcase
            end

            MODE_END: begin
              endq_nxt = 1'b1;
            end

            MODE_TICK: begin
              if (armed_r && !medium_r) begin
                aerr_nxt  = 1'b1;
                busy_nxt  = 1'b0;
                irq_nxt   = 1'b1;
                armed_nxt = 1'b0;
              end else if (armed_r) begin
                ca_nxt = ca_r + CA_W'(tk_cnt);
                if (tk_write) begin
                  par_nxt = tk_wpar;
                  hi_we   = ca_r[0] ? tk_succ[1] : tk_succ[0];
                  lo_we   = ca_r[0] ? tk_succ[0] : tk_succ[1];
                  if (tk_succ[2]) begin
                    wr2_nxt.lo_lane = ca_r[0];
                    wr2_nxt.addr    = a_next;
                    wr2_nxt.data    = wb2;
                    seq_nxt         = SQ_WRITE2;
                  end
                end else if (tk_succ[0]) begin
                  // bytes come back next cycle; the result waits for them
                  hi_re         = ca_r[0] ? tk_succ[1] : tk_succ[0];
                  lo_re         = ca_r[0] ? tk_succ[0] : tk_succ[1];
                  pend_nxt.two  = tk_succ[1];
                  pend_nxt.load = tk_succ[1] && !tk_end;
                  pend_nxt.chk  = tk_end;
                  pend_nxt.odd  = ca_r[0];
                  hold_dat_nxt  = in_bus_data;
                  seq_nxt       = SQ_READ;
                  push          = 1'b0;
                end else if (tk_end && par_r) begin
                  derr_nxt = 1'b1;
                end
                if (tk_fault) begin
                  aerr_nxt  = 1'b1;
                  busy_nxt  = 1'b0;
                  irq_nxt   = 1'b1;
                  armed_nxt = 1'b0;
                end
                if (tk_end) begin
                  if (rdy_r) begin
                    derr_nxt = 1'b1;
                  end
                  busy_nxt  = 1'b0;
                  irq_nxt   = 1'b1;
                  armed_nxt = 1'b0;
                end else if (!tk_fault) begin
                  rdy_nxt = 1'b1;
                end
              end
            end

            default: begin
            end
          endcase
        end
      end

      SQ_READ: begin
        par_nxt = rd_par;
        if (pend_r.load) begin
          buf_nxt = {rd_c1, rd_c2};
        end
        if (pend_r.chk && rd_par) begin
          derr_nxt = 1'b1;
        end
        res_rd  = hold_dat_r;
        push    = 1'b1;
        seq_nxt = SQ_RUN;
      end

      SQ_WRITE2: begin
        hi_addr  = wr2_r.addr;
        lo_addr  = wr2_r.addr;
        hi_wdata = wr2_r.data;
        lo_wdata = wr2_r.data;
        hi_we    = !wr2_r.lo_lane;
        lo_we    = wr2_r.lo_lane;
        seq_nxt  = SQ_RUN;
      end

      default: begin
        seq_nxt = SQ_RUN;
      end
    endcase

    push_res.skip  = res_skip;
    push_res.bad   = res_bad;
    push_res.rdata = res_rd;
    push_res.rdy   = rdy_nxt;
    push_res.busy  = busy_nxt;
    push_res.derr  = derr_nxt;
    push_res.aerr  = aerr_nxt;
    push_res.endq  = endq_nxt;
    push_res.irq   = irq_nxt;
  end

  // result buffer: head register plus one skid entry
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_valid_r && !pop) begin
      if (push) begin
        skid_nxt       = push_res;
        skid_valid_nxt = 1'b1;
      end
    end else if (skid_valid_r) begin
      out_nxt        = skid_r;
      out_valid_nxt  = 1'b1;
      skid_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = push;
      if (push) begin
        out_nxt = push_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r        <= SQ_CLEAR;
      clr_addr_r   <= '0;
      medium_r     <= 1'b1;
      nsurf_r      <= SURF_W'(1);
      cmd1_r       <= '0;
      ca_r         <= '0;
      buf_r        <= '0;
      phase_r      <= PH_IDLE;
      busy_r       <= 1'b0;
      rdy_r        <= 1'b0;
      derr_r       <= 1'b0;
      aerr_r       <= 1'b0;
      endq_r       <= 1'b0;
      par_r        <= 1'b0;
      irq_r        <= 1'b0;
      armed_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      seq_r        <= seq_nxt;
      clr_addr_r   <= clr_addr_nxt;
      cmd1_r       <= cmd1_nxt;
      ca_r         <= ca_nxt;
      buf_r        <= buf_nxt;
      phase_r      <= phase_nxt;
      busy_r       <= busy_nxt;
      rdy_r        <= rdy_nxt;
      derr_r       <= derr_nxt;
      aerr_r       <= aerr_nxt;
      endq_r       <= endq_nxt;
      par_r        <= par_nxt;
      irq_r        <= irq_nxt;
      armed_r      <= armed_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MEDIUM:   medium_r <= cfg_wdata[0];
          CFG_SURFACES: nsurf_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    hold_dat_r <= hold_dat_nxt;
    wr2_r      <= wr2_nxt;
    out_r      <= out_nxt;
    skid_r     <= skid_nxt;
  end

  always_ff @(posedge clk) begin
    if (hi_we) begin
      hi_mem[hi_addr] <= hi_wdata;
    end
    if (hi_re) begin
      hi_q_r <= hi_mem[hi_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (lo_we) begin
      lo_mem[lo_addr] <= lo_wdata;
    end
    if (lo_re) begin
      lo_q_r <= lo_mem[lo_addr];
    end
  end

  assign out_valid             = out_valid_r;
  assign out_skip              = out_r.skip;
  assign out_bad_function      = out_r.bad;
  assign out_read_data         = out_r.rdata;
  assign out_ready_flag        = out_r.rdy;
  assign out_busy_flag         = out_r.busy;
  assign out_data_error_flag   = out_r.derr;
  assign out_access_error_flag = out_r.aerr;
  assign out_end_flag          = out_r.endq;
  assign out_interrupt_request = out_r.irq;

  `FHDC_ASSERT_IMPL(a_push_room, push, !skid_valid_r, "result pushed into a full buffer")
  `FHDC_ASSERT_IMPL(a_skid_order, skid_valid_r, out_valid_r, "skid entry without head entry")
  `FHDC_ASSERT_IMPL(a_read_push, seq_r == SQ_READ, push, "read tick result not delivered")
  `FHDC_ASSERT_IMPL(a_armed_busy, armed_r, busy_r, "transfer armed while not busy")
  `FHDC_ASSERT_NEXT(a_write2_back, seq_r == SQ_WRITE2, seq_r == SQ_RUN, "second write stuck")

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the fixed head disk controller: bus accesses against a predictor
`timescale 1ns / 1ps

module testbench;
  import fhdc_pkg::*;

  localparam int         CYCLE_LIMIT = 1_000_000;
  localparam int         PHASES      = 7;
  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam logic [3:0] FN_ILLEGAL  = 4'hF;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SURF_W-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic [2:0]           in_mode;
  logic [3:0]           in_function_code;
  logic [15:0]          in_bus_data;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_skip;
  logic                 out_bad_function;
  logic [15:0]          out_read_data;
  logic                 out_ready_flag;
  logic                 out_busy_flag;
  logic                 out_data_error_flag;
  logic                 out_access_error_flag;
  logic                 out_end_flag;
  logic                 out_interrupt_request;

  fixed_head_disk_controller_unit i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_mode              (in_mode),
    .in_function_code     (in_function_code),
    .in_bus_data          (in_bus_data),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_skip             (out_skip),
    .out_bad_function     (out_bad_function),
    .out_read_data        (out_read_data),
    .out_ready_flag       (out_ready_flag),
    .out_busy_flag        (out_busy_flag),
    .out_data_error_flag  (out_data_error_flag),
    .out_access_error_flag(out_access_error_flag),
    .out_end_flag         (out_end_flag),
    .out_interrupt_request(out_interrupt_request)
  );

  always #1 clk = ~clk;

  // controller model state
  bit          cfg_medium;
  logic [4:0]  cfg_surfaces;
  logic [15:0] dk_cmd;
  logic [11:0] dk_addr;
  logic [15:0] dk_buf;
  phase_t      dk_phase;
  bit          dk_busy, dk_ready, dk_derr, dk_aerr, dk_endq, dk_parity, dk_irq, dk_armed;
  bit   [15:0] dk_image [STORE_WORDS];

  res_t bus_replies [$];
  int   fail_count;
  int   items_sent;
  int   replies_seen;
  int   tx_level;
  bit   quiet_tail;
  int   cycle_count;

  typedef struct {
    logic [2:0]  mode;
    logic [3:0]  fnc;
    logic [15:0] data;
    bit          typed;
    res_t        want;
  } access_row_t;

  // typed rows: skip, bad function, read data; every flag is still clear after reset
  access_row_t directed_rows [25] = '{
    '{MODE_SENSE, SNS_READY,    16'hFFFF, 1'b1, {1'b0, 1'b0, 16'hFFFF, 6'b0}},
    '{MODE_SENSE, SNS_NOT_BUSY, 16'h0000, 1'b1, {1'b1, 1'b0, 16'h0000, 6'b0}},
    '{MODE_SENSE, SNS_NO_DERR,  16'h0000, 1'b1, {1'b1, 1'b0, 16'h0000, 6'b0}},
    '{MODE_SENSE, SNS_NO_AERR,  16'h0000, 1'b1, {1'b1, 1'b0, 16'h0000, 6'b0}},
    '{MODE_SENSE, SNS_NO_IRQ,   16'h0000, 1'b1, {1'b1, 1'b0, 16'h0000, 6'b0}},
    '{MODE_SENSE, FN_ILLEGAL,   16'h5A5A, 1'b1, {1'b0, 1'b0, 16'h5A5A, 6'b0}},
    '{MODE_UNUSED, FN_ILLEGAL,  16'hFFFF, 1'b1, {1'b0, 1'b0, 16'hFFFF, 6'b0}},
    '{MODE_CTRL,  FN_NONE,      16'h0000, 1'b1, {1'b0, 1'b1, 16'h0000, 6'b0}},
    '{MODE_CTRL,  FN_ILLEGAL,   16'hFFFF, 1'b1, {1'b0, 1'b1, 16'hFFFF, 6'b0}},
    '{MODE_OUT,   FN_ILLEGAL,   16'h1234, 1'b1, {1'b0, 1'b1, 16'h1234, 6'b0}},
    '{MODE_TICK,  FN_NONE,      16'h0000, 1'b1, {1'b0, 1'b0, 16'h0000, 6'b0}},
    '{MODE_OUT,   FN_NONE,      16'hFFFF, 1'b1, {1'b0, 1'b0, 16'hFFFF, 6'b0}},
    '{MODE_IN,    FN_NONE,      16'h0000, 1'b1, {1'b0, 1'b0, 16'h0000, 6'b0}},
    // write to the last word of track 63, then overrun on the first tick
    '{MODE_CTRL,  FN_START,     16'h0000, 1'b0, '0},
    '{MODE_CTRL,  FN_START_ALT, 16'h0000, 1'b0, '0},
    '{MODE_OUT,   FN_NONE,      16'h83F0, 1'b0, '0},
    '{MODE_OUT,   FN_NONE,      16'h0BFE, 1'b0, '0},
    '{MODE_TICK,  FN_NONE,      16'h0000, 1'b0, '0},
    // surface not installed
    '{MODE_CTRL,  FN_START,     16'h0000, 1'b0, '0},
    '{MODE_OUT,   FN_NONE,      16'h8400, 1'b0, '0},
    '{MODE_OUT,   FN_NONE,      16'h0000, 1'b0, '0},
    // character address past the end of the track
    '{MODE_CTRL,  FN_START,     16'h0000, 1'b0, '0},
    '{MODE_OUT,   FN_NONE,      16'h0000, 1'b0, '0},
    '{MODE_OUT,   FN_NONE,      16'h0C00, 1'b0, '0},
    '{MODE_END,   FN_NONE,      16'hFFFF, 1'b0, '0}
  };

  bit         phase_medium [PHASES] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
  logic [4:0] phase_surf   [PHASES] = '{5'd1, 5'd2, 5'd16, 5'd2, 5'd0, 5'd31, 5'd2};
  int         phase_items  [PHASES] = '{200, 400, 250, 100, 100, 150, 300};

  function automatic void abort_on_fault();
    dk_aerr  = 1'b1;
    dk_busy  = 1'b0;
    dk_irq   = 1'b1;
    dk_armed = 1'b0;
  endfunction

  function automatic bit word_index(output int unsigned idx);
    int unsigned wa, sf, tk, a;
    wa  = dk_addr >> 1;
    sf  = dk_cmd[13:10];
    tk  = dk_cmd[9:4];
    idx = 0;
    if (wa >= WORDS_PER_TRACK) begin
      abort_on_fault();
      return 1'b0;
    end
    a = (sf * TRACKS_PER_SURFACE + tk) * WORDS_PER_TRACK + wa;
    if (a >= STORE_WORDS) begin
      abort_on_fault();
      return 1'b0;
    end
    idx = a;
    return 1'b1;
  endfunction

  function automatic bit store_char(input logic [7:0] ch);
    int unsigned idx;
    if (!word_index(idx)) return 1'b0;
    if (dk_addr[0]) dk_image[idx][7:0] = ch;
    else dk_image[idx][15:8] = ch;
    dk_addr   = dk_addr + 12'd1;
    dk_parity = dk_parity ^ (^ch);
    return 1'b1;
  endfunction

  function automatic bit fetch_char(output logic [7:0] ch);
    int unsigned idx;
    ch = 8'h00;
    if (!word_index(idx)) return 1'b0;
    ch        = dk_addr[0] ? dk_image[idx][7:0] : dk_image[idx][15:8];
    dk_addr   = dk_addr + 12'd1;
    dk_parity = dk_parity ^ (^ch);
    return 1'b1;
  endfunction

  function automatic void begin_transfer();
    if (dk_busy) return;
    dk_busy   = 1'b1;
    dk_endq   = 1'b0;
    dk_parity = 1'b0;
    dk_derr   = 1'b0;
    dk_aerr   = 1'b0;
    dk_phase  = PH_CW1;
    dk_ready  = 1'b1;
  endfunction

  function automatic void load_address(input logic [15:0] dat);
    int unsigned sf, tk, nsf;
    sf       = dk_cmd[13:10];
    tk       = dk_cmd[9:4];
    nsf      = (cfg_surfaces > MAX_SURFACES) ? MAX_SURFACES : cfg_surfaces;
    dk_addr  = dat[11:0];
    dk_phase = PH_IDLE;
    if ((dk_addr >> 1) >= WORDS_PER_TRACK || !cfg_medium || sf >= nsf ||
        tk >= TRACKS_PER_SURFACE) begin
      // armed stays as it was
      dk_aerr = 1'b1;
      dk_busy = 1'b0;
      dk_irq  = 1'b1;
      return;
    end
    dk_ready = dk_cmd[CMD_WRITE_BIT];
    dk_armed = 1'b1;
  endfunction

  function automatic void move_word();
    logic [7:0] hi, lo;
    bit         wr;
    wr = dk_cmd[CMD_WRITE_BIT];
    if (!dk_armed) return;
    if (!cfg_medium) begin
      abort_on_fault();
      return;
    end
    if (dk_endq || dk_ready) begin
      if (dk_ready) dk_derr = 1'b1;
      if (wr) begin
        if (!dk_ready) begin
          void'(store_char(dk_buf[15:8]));
          void'(store_char(dk_buf[7:0]));
        end
        void'(store_char(dk_parity ? 8'o200 : 8'h00));
      end else begin
        void'(fetch_char(hi));
        if (dk_parity) dk_derr = 1'b1;
      end
      dk_busy  = 1'b0;
      dk_irq   = 1'b1;
      dk_armed = 1'b0;
      return;
    end
    if (wr) begin
      if (!store_char(dk_buf[15:8])) return;
      if (!store_char(dk_buf[7:0])) return;
    end else begin
      if (!fetch_char(hi)) return;
      if (!fetch_char(lo)) return;
      dk_buf = {hi, lo};
    end
    dk_ready = 1'b1;
  endfunction

  function automatic res_t predict_access(input logic [2:0] mode, input logic [3:0] fnc,
                                          input logic [15:0] dat);
    res_t r;
    r       = '0;
    r.rdata = dat;
    case (mode)
      MODE_CTRL: begin
        if (fnc == FN_STOP) begin
          dk_endq = 1'b1;
          dk_irq  = 1'b0;
        end else if (fnc == FN_START || fnc == FN_START_ALT) begin
          begin_transfer();
        end else begin
          r.bad = 1'b1;
        end
      end
      MODE_OUT: begin
        if (fnc != FN_NONE) begin
          r.bad = 1'b1;
        end else if (dk_ready) begin
          dk_buf = dat;
          if (dk_phase == PH_CW1) begin
            dk_cmd   = dat;
            dk_phase = PH_CW2;
          end else if (dk_phase == PH_CW2) begin
            load_address(dat);
          end else begin
            dk_ready = 1'b0;
          end
          r.skip = 1'b1;
        end
      end
      MODE_IN: begin
        if (fnc != FN_NONE) begin
          r.bad = 1'b1;
        end else if (dk_ready) begin
          dk_ready = 1'b0;
          r.rdata  = dat | dk_buf;
          r.skip   = 1'b1;
        end
      end
      MODE_SENSE: begin
        r.skip = (fnc == SNS_READY && dk_ready) || (fnc == SNS_NOT_BUSY && !dk_busy) ||
                 (fnc == SNS_NO_DERR && !dk_derr) || (fnc == SNS_NO_AERR && !dk_aerr) ||
                 (fnc == SNS_NO_IRQ && !dk_irq);
      end
      MODE_END:  dk_endq = 1'b1;
      MODE_TICK: move_word();
      default: ;
    endcase
    r.rdy  = dk_ready;
    r.busy = dk_busy;
    r.derr = dk_derr;
    r.aerr = dk_aerr;
    r.endq = dk_endq;
    r.irq  = dk_irq;
    return r;
  endfunction

  task automatic check_reply(input res_t got);
    res_t want;
    if (bus_replies.size() == 0) begin
      $error("result with no item waiting: %h", got);
      fail_count++;
      return;
    end
    want = bus_replies.pop_front();
    if (got.skip !== want.skip) begin
      $error("skip: expected %0d, got %0d", want.skip, got.skip);
      fail_count++;
    end
    if (got.bad !== want.bad) begin
      $error("bad_function: expected %0d, got %0d", want.bad, got.bad);
      fail_count++;
    end
    if (got.rdata !== want.rdata) begin
      $error("read_data: expected %h, got %h", want.rdata, got.rdata);
      fail_count++;
    end
    if (got.rdy !== want.rdy) begin
      $error("ready_flag: expected %0d, got %0d", want.rdy, got.rdy);
      fail_count++;
    end
    if (got.busy !== want.busy) begin
      $error("busy_flag: expected %0d, got %0d", want.busy, got.busy);
      fail_count++;
    end
    if (got.derr !== want.derr) begin
      $error("data_error_flag: expected %0d, got %0d", want.derr, got.derr);
      fail_count++;
    end
    if (got.aerr !== want.aerr) begin
      $error("access_error_flag: expected %0d, got %0d", want.aerr, got.aerr);
      fail_count++;
    end
    if (got.endq !== want.endq) begin
      $error("end_flag: expected %0d, got %0d", want.endq, got.endq);
      fail_count++;
    end
    if (got.irq !== want.irq) begin
      $error("interrupt_request: expected %0d, got %0d", want.irq, got.irq);
      fail_count++;
    end
  endtask

  task automatic send_access(input logic [2:0] mode, input logic [3:0] fnc,
                             input logic [15:0] data, input bit typed = 1'b0,
                             input res_t want = '0);
    res_t reply;
    if (!quiet_tail && $urandom_range(0, 7) < tx_level) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= mode;
    in_function_code <= fnc;
    in_bus_data      <= data;
    do @(posedge clk); while (!in_ready);
    reply = predict_access(mode, fnc, data);
    bus_replies.push_back(typed ? want : reply);
    items_sent++;
  endtask

  task automatic set_config(input bit attached, input logic [4:0] surfaces);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MEDIUM;
    cfg_wdata <= SURF_W'(attached);
    @(posedge clk);
    cfg_index <= CFG_SURFACES;
    cfg_wdata <= surfaces;
    @(posedge clk);
    cfg_we       <= 1'b0;
    cfg_medium   = attached;
    cfg_surfaces = surfaces;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (bus_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one transfer: start, two command words, a few words, then an optional end and a closing tick
  task automatic run_transfer();
    bit          wr;
    int unsigned sf, tk, ca, nsf;
    logic [15:0] cw1;
    wr  = $urandom_range(0, 1);
    nsf = (cfg_surfaces > MAX_SURFACES) ? MAX_SURFACES : cfg_surfaces;
    if (nsf == 0 || $urandom_range(0, 9) == 0) sf = $urandom_range(0, 15);
    else sf = $urandom_range(0, nsf - 1);
    case ($urandom_range(0, 3))
      0:       tk = 0;
      1:       tk = 1;
      2:       tk = TRACKS_PER_SURFACE - 1;
      default: tk = $urandom_range(0, TRACKS_PER_SURFACE - 1);
    endcase
    // mostly the head of the track so reads find written words
    case ($urandom_range(0, 9))
      0:       ca = $urandom_range(CHARS_PER_TRACK, 4095);
      1:       ca = $urandom_range(CHARS_PER_TRACK - 16, CHARS_PER_TRACK - 1);
      default: ca = $urandom_range(0, 15);
    endcase
    cw1      = {wr, 1'($urandom), 4'(sf), 6'(tk), 4'($urandom)};
    tx_level = $urandom_range(0, 3);
    send_access(MODE_CTRL, $urandom_range(0, 1) ? FN_START : FN_START_ALT, 16'($urandom));
    send_access(MODE_OUT, FN_NONE, cw1);
    send_access(MODE_OUT, FN_NONE, {4'($urandom), 12'(ca)});
    repeat ($urandom_range(0, 6)) begin
      if (wr) begin
        // a missing data word gives an overrun
        if ($urandom_range(0, 9) != 0) send_access(MODE_OUT, FN_NONE, 16'($urandom));
        send_access(MODE_TICK, 4'($urandom), 16'($urandom));
      end else begin
        send_access(MODE_TICK, 4'($urandom), 16'($urandom));
        if ($urandom_range(0, 9) != 0)
          send_access(MODE_IN, FN_NONE, $urandom_range(0, 1) ? 16'h0000 : 16'($urandom));
      end
      if ($urandom_range(0, 5) == 0)
        send_access(MODE_SENSE, 4'($urandom_range(0, 4)), 16'($urandom));
    end
    case ($urandom_range(0, 7))
      0: ;
      1, 2, 3: send_access(MODE_END, 4'($urandom), 16'($urandom));
      default: send_access(MODE_CTRL, FN_STOP, 16'($urandom));
    endcase
    send_access(MODE_TICK, 4'($urandom), 16'($urandom));
    if ($urandom_range(0, 2) == 0)
      send_access(MODE_SENSE, 4'($urandom_range(0, 4)), 16'($urandom));
  endtask

  initial begin : stimulus
    int target;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_MEDIUM;
    cfg_wdata        = '0;
    in_valid         = 1'b0;
    in_mode          = MODE_CTRL;
    in_function_code = FN_NONE;
    in_bus_data      = 16'h0000;
    cfg_medium       = 1'b1;
    cfg_surfaces     = 5'd1;
    dk_cmd           = '0;
    dk_addr          = '0;
    dk_buf           = '0;
    dk_phase         = PH_IDLE;
    {dk_busy, dk_ready, dk_derr, dk_aerr, dk_endq, dk_parity, dk_irq, dk_armed} = '0;
    fail_count       = 0;
    items_sent       = 0;
    tx_level         = 1;
    quiet_tail       = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      set_config(phase_medium[p], phase_surf[p]);
      quiet_tail = (p == PHASES - 1);
      if (p == 0) begin
        foreach (directed_rows[i])
          send_access(directed_rows[i].mode, directed_rows[i].fnc, directed_rows[i].data,
                      directed_rows[i].typed, directed_rows[i].want);
      end
      target = items_sent + phase_items[p];
      while (items_sent < target) begin
        if ($urandom_range(0, 4) == 0) begin
          tx_level = $urandom_range(0, 3);
          repeat ($urandom_range(1, 3))
            send_access(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), 16'($urandom));
        end else begin
          run_transfer();
        end
      end
      settle();
    end
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

  initial begin : reply_sink
    int   stall_left;
    int   rx_level;
    bit   held;
    res_t got;
    out_ready    = 1'b0;
    replies_seen = 0;
    stall_left   = 0;
    rx_level     = 1;
    held         = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got = {out_skip, out_bad_function, out_read_data, out_ready_flag, out_busy_flag,
               out_data_error_flag, out_access_error_flag, out_end_flag,
               out_interrupt_request};
        check_reply(got);
        replies_seen++;
      end
      if ($urandom_range(0, 63) == 0) rx_level = $urandom_range(0, 3);
      // one long hold-off so the result buffer fills and the input stalls
      if (!held && replies_seen >= 500) begin
        held       = 1'b1;
        stall_left = 400;
      end else if (stall_left == 0 && !quiet_tail && $urandom_range(0, 7) < rx_level) begin
        stall_left = $urandom_range(1, 7);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // the clearing sweep after reset is counted too
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench failed");
    $finish;
  end

endmodule
